### rtl/core/ttcb_pkg.sv
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared codes, widths and controller/datapath signal groups for the text
// terminal cell buffer.
// ----------------------------------------------------------------------------
package ttcb_pkg;

	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int CELL_W  = 16;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN   = 8'd13;
	localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h1F;

	localparam logic REG_TEXT_COLOR = 1'b0;
	localparam logic REG_BACK_COLOR = 1'b1;

	typedef struct packed {
		logic take;
		logic exec;
		logic cnt_clr;
		logic cnt_inc;
		logic copy_en;
		logic fill_en;
		logic fill_init;
		logic out_load;
		logic out_direct;
	} cmd_t;

	typedef struct packed {
		logic op_put;
		logic op_read;
		logic op_clear;
		logic need_scroll;
		logic copy_last;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/ttcb_in_if.sv
// ----------------------------------------------------------------------------
// ttcb_in_if
// Request channel: operation, byte and cell index with valid/ready.
// ----------------------------------------------------------------------------
interface ttcb_in_if #(
	parameter int IDX_W = 9
);
	logic                           valid;
	logic                           ready;
	logic [ttcb_pkg::OP_W-1:0]      op;
	logic [ttcb_pkg::CHAR_W-1:0]    char_code;
	logic [IDX_W-1:0]               cell_index;

	modport source (output valid, output op, output char_code, output cell_index, input ready);
	modport sink (input valid, input op, input char_code, input cell_index, output ready);
endinterface

### rtl/core/ttcb_out_if.sv
// ----------------------------------------------------------------------------
// ttcb_out_if
// Result channel: cursor, touched cell and flags with valid/ready.
// ----------------------------------------------------------------------------
interface ttcb_out_if #(
	parameter int COL_W  = 5,
	parameter int ROW_W  = 4,
	parameter int ADDR_W = 9
);
	logic                           valid;
	logic                           ready;
	logic [COL_W-1:0]               cursor_col;
	logic [ROW_W-1:0]               cursor_row;
	logic [ADDR_W-1:0]              cell_addr;
	logic [ttcb_pkg::CELL_W-1:0]    cell_value;
	logic                           wrote_cell;
	logic                           scrolled;

	modport source (
		output valid, output cursor_col, output cursor_row, output cell_addr,
		output cell_value, output wrote_cell, output scrolled, input ready
	);
	modport sink (
		input valid, input cursor_col, input cursor_row, input cell_addr,
		input cell_value, input wrote_cell, input scrolled, output ready
	);
endinterface

### rtl/core/text_terminal_cell_buffer.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer
// Character-cell text buffer with cursor, wrap and upward scroll.
// Result: registered from EXEC for a put without scroll, from RDWAIT for a
// cell read and from DONE after the sweeps for a scroll or clear, each once the
// output register is free. A scroll runs the one-cell-per-cycle row copy and
// fill sweep through the cell RAM, a clear the fill sweep alone; no request
// is taken until the result is loaded. Reset: cursor homed, colors 0x1F; a
// fill pass writes 0x1F00 to every cell while no request is accepted.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer #(
	parameter int COLUMNS = 30,
	parameter int ROWS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ttcb_pkg::PADDR_W-1:0]    paddr,
	input  logic [ttcb_pkg::DATA_W-1:0]     pwdata,
	output logic [ttcb_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	ttcb_in_if.sink                         req,
	ttcb_out_if.source                      rsp
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	ttcb_pkg::cmd_t                 cmd;
	ttcb_pkg::sts_t                 sts;
	logic [ttcb_pkg::CHAR_W-1:0]    text_color;
	logic [ttcb_pkg::CHAR_W-1:0]    back_color;
	logic                           ram_we;
	logic [ADDR_W-1:0]              ram_waddr;
	logic [ttcb_pkg::CELL_W-1:0]    ram_wdata;
	logic                           ram_re;
	logic [ADDR_W-1:0]              ram_raddr;
	logic [ttcb_pkg::CELL_W-1:0]    ram_rdata;
	logic                           in_ready;

	assign req.ready = in_ready;

	ttcb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.text_color (text_color),
		.back_color (back_color)
	);

	ttcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ttcb_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_op        (req.op),
		.in_char      (req.char_code),
		.in_index     (req.cell_index),
		.text_color   (text_color),
		.back_color   (back_color),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.out_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.out_col      (rsp.cursor_col),
		.out_row      (rsp.cursor_row),
		.out_addr     (rsp.cell_addr),
		.out_value    (rsp.cell_value),
		.out_wrote    (rsp.wrote_cell),
		.out_scrolled (rsp.scrolled)
	);

	ttcb_ram #(
		.WIDTH (ttcb_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### rtl/core/ttcb_ram.sv
// ----------------------------------------------------------------------------
// ttcb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttcb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 480,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/ttcb_regs.sv
// ----------------------------------------------------------------------------
// ttcb_regs
// APB configuration registers: text color and back color.
// ----------------------------------------------------------------------------
module ttcb_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ttcb_pkg::PADDR_W-1:0]      paddr,
	input  logic [ttcb_pkg::DATA_W-1:0]       pwdata,
	output logic [ttcb_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	output logic [ttcb_pkg::CHAR_W-1:0]       text_color,
	output logic [ttcb_pkg::CHAR_W-1:0]       back_color
);

	logic                          reg_idx;
	logic                          wr_en;
	logic [ttcb_pkg::CHAR_W-1:0]   rd_val;
	logic [ttcb_pkg::CHAR_W-1:0]   text_color_q;
	logic [ttcb_pkg::CHAR_W-1:0]   back_color_q;

	assign reg_idx = paddr[ttcb_pkg::PADDR_W-1];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= ttcb_pkg::RESET_COLOR;
			back_color_q <= ttcb_pkg::RESET_COLOR;
		end else if (wr_en) begin
			unique case (reg_idx)
				ttcb_pkg::REG_TEXT_COLOR: text_color_q <= pwdata[ttcb_pkg::CHAR_W-1:0];
				ttcb_pkg::REG_BACK_COLOR: back_color_q <= pwdata[ttcb_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ttcb_pkg::REG_TEXT_COLOR: rd_val = text_color_q;
			ttcb_pkg::REG_BACK_COLOR: rd_val = back_color_q;
			default:                  rd_val = '0;
		endcase
	end

	assign prdata     = {{(ttcb_pkg::DATA_W-ttcb_pkg::CHAR_W){1'b0}}, rd_val};
	assign text_color = text_color_q;
	assign back_color = back_color_q;

endmodule

### rtl/core/ttcb_ctrl.sv
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Controller: sequences reset fill, op execution, scroll copy and clear
// sweeps, and result hand-off.
// ----------------------------------------------------------------------------
module ttcb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ttcb_pkg::sts_t  sts,
	output ttcb_pkg::cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_EXEC   = 7'b0000100,
		ST_RDWAIT = 7'b0001000,
		ST_COPY   = 7'b0010000,
		ST_FILL   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill_en   = 1'b1;
				cmd.fill_init = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.op_read) begin
					cmd.exec = 1'b1;
					state_d  = ST_RDWAIT;
				end else if (sts.op_clear) begin
					cmd.exec    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_FILL;
				end else if (sts.op_put && sts.need_scroll) begin
					cmd.exec    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_COPY;
				end else if (sts.out_free) begin
					cmd.exec       = 1'b1;
					cmd.out_load   = 1'b1;
					cmd.out_direct = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_RDWAIT, ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_COPY: begin
				cmd.copy_en = 1'b1;
				if (sts.copy_last) begin
					state_d = ST_FILL;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_FILL: begin
				cmd.fill_en = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

endmodule

### rtl/core/ttcb_dp.sv
// ----------------------------------------------------------------------------
// ttcb_dp
// Datapath: cursor, cell address and value, sweep counter, RAM port muxing
// and the result register.
// ----------------------------------------------------------------------------
module ttcb_dp #(
	parameter int COLUMNS = 30,
	parameter int ROWS = 16,
	localparam int CELLS = COLUMNS * ROWS,
	localparam int COL_W = $clog2(COLUMNS),
	localparam int ROW_W = $clog2(ROWS),
	localparam int ADDR_W = $clog2(CELLS),
	localparam int CNT_W = $clog2(CELLS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ttcb_pkg::cmd_t                  cmd,
	output ttcb_pkg::sts_t                  sts,
	input  logic [ttcb_pkg::OP_W-1:0]       in_op,
	input  logic [ttcb_pkg::CHAR_W-1:0]     in_char,
	input  logic [ADDR_W-1:0]               in_index,
	input  logic [ttcb_pkg::CHAR_W-1:0]     text_color,
	input  logic [ttcb_pkg::CHAR_W-1:0]     back_color,
	output logic                            ram_we,
	output logic [ADDR_W-1:0]               ram_waddr,
	output logic [ttcb_pkg::CELL_W-1:0]     ram_wdata,
	output logic                            ram_re,
	output logic [ADDR_W-1:0]               ram_raddr,
	input  logic [ttcb_pkg::CELL_W-1:0]     ram_rdata,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [COL_W-1:0]                out_col,
	output logic [ROW_W-1:0]                out_row,
	output logic [ADDR_W-1:0]               out_addr,
	output logic [ttcb_pkg::CELL_W-1:0]     out_value,
	output logic                            out_wrote,
	output logic                            out_scrolled
);

	// captured request
	logic [ttcb_pkg::OP_W-1:0]      op_q;
	logic [ttcb_pkg::CHAR_W-1:0]    char_q;
	logic [ADDR_W-1:0]              idx_q;

	logic [COL_W-1:0]               col_q;
	logic [ROW_W-1:0]               row_q;
	logic [CNT_W-1:0]               cnt_q;

	// result held across multi-cycle ops
	logic [ADDR_W-1:0]              res_addr_q;
	logic [ttcb_pkg::CELL_W-1:0]    res_value_q;
	logic                           res_wrote_q;
	logic                           res_scr_q;

	logic                           out_valid_q;
	logic [COL_W-1:0]               out_col_q;
	logic [ROW_W-1:0]               out_row_q;
	logic [ADDR_W-1:0]              out_addr_q;
	logic [ttcb_pkg::CELL_W-1:0]    out_value_q;
	logic                           out_wrote_q;
	logic                           out_scr_q;

	logic                           is_nl;
	logic                           is_cr;
	logic                           at_right;
	logic                           at_bottom;
	logic                           in_range;
	logic                           copy_last;
	logic                           fill_last;
	logic                           line_feed;
	logic [ADDR_W-1:0]              cur_addr;
	logic [ttcb_pkg::CHAR_W-1:0]    fill_color;
	logic [ttcb_pkg::CELL_W-1:0]    held_value;

	logic [COL_W-1:0]               nxt_col;
	logic [ROW_W-1:0]               nxt_row;
	logic [ADDR_W-1:0]              nxt_addr;
	logic [ttcb_pkg::CELL_W-1:0]    nxt_value;
	logic                           nxt_wrote;
	logic                           nxt_scr;

	assign is_nl     = (char_q == ttcb_pkg::CH_NEWLINE);
	assign is_cr     = (char_q == ttcb_pkg::CH_RETURN);
	assign at_right  = (col_q == COL_W'(COLUMNS - 1));
	assign at_bottom = (row_q == ROW_W'(ROWS - 1));
	assign in_range  = (CNT_W'(idx_q) < CNT_W'(CELLS));
	assign copy_last = (cnt_q == CNT_W'(CELLS - COLUMNS));
	assign fill_last = (cnt_q == CNT_W'(CELLS - 1));
	assign cur_addr  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

	// next cursor and result for the captured op
	always_comb begin
		nxt_col   = col_q;
		nxt_row   = row_q;
		nxt_addr  = '0;
		nxt_value = '0;
		nxt_wrote = 1'b0;
		nxt_scr   = 1'b0;
		line_feed = 1'b0;
		unique case (op_q)
			ttcb_pkg::OP_PUT: begin
				if (is_nl) begin
					line_feed = 1'b1;
				end else if (is_cr) begin
					nxt_col = '0;
				end else begin
					nxt_addr  = cur_addr;
					nxt_value = {text_color, char_q};
					nxt_wrote = 1'b1;
					if (at_right) begin
						line_feed = 1'b1;
					end else begin
						nxt_col = col_q + COL_W'(1);
					end
				end
				if (line_feed) begin
					nxt_col = '0;
					if (at_bottom) begin
						nxt_scr = 1'b1;
					end else begin
						nxt_row = row_q + ROW_W'(1);
					end
				end
			end
			ttcb_pkg::OP_READ: nxt_addr = idx_q;
			ttcb_pkg::OP_CLEAR: begin
				nxt_col = '0;
				nxt_row = '0;
			end
			default: ;
		endcase
	end

	assign sts.op_put      = (op_q == ttcb_pkg::OP_PUT);
	assign sts.op_read     = (op_q == ttcb_pkg::OP_READ);
	assign sts.op_clear    = (op_q == ttcb_pkg::OP_CLEAR);
	assign sts.need_scroll = nxt_scr;
	assign sts.copy_last   = copy_last;
	assign sts.fill_last   = fill_last;
	assign sts.out_free    = !out_valid_q || out_ready;

	assign fill_color = cmd.fill_init ? ttcb_pkg::RESET_COLOR : back_color;

	// cell store port muxing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = {fill_color, {ttcb_pkg::CHAR_W{1'b0}}};
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		if (cmd.fill_en) begin
			ram_we = 1'b1;
		end else if (cmd.copy_en) begin
			ram_we    = (cnt_q != '0);
			ram_waddr = ADDR_W'(cnt_q - CNT_W'(1));
			ram_wdata = ram_rdata;
		end else if (cmd.exec && nxt_wrote) begin
			ram_we    = 1'b1;
			ram_waddr = nxt_addr;
			ram_wdata = nxt_value;
		end
		if (cmd.copy_en) begin
			ram_re    = !copy_last;
			ram_raddr = ADDR_W'(cnt_q + CNT_W'(COLUMNS));
		end else begin
			ram_re = cmd.exec && sts.op_read && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= in_op;
			char_q <= in_char;
			idx_q  <= in_index;
		end
		if (cmd.exec) begin
			res_addr_q  <= nxt_addr;
			res_value_q <= nxt_value;
			res_wrote_q <= nxt_wrote;
			res_scr_q   <= nxt_scr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.exec) begin
				col_q <= nxt_col;
				row_q <= nxt_row;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign held_value = sts.op_read ? (in_range ? ram_rdata : '0) : res_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_direct) begin
				out_col_q   <= nxt_col;
				out_row_q   <= nxt_row;
				out_addr_q  <= nxt_addr;
				out_value_q <= nxt_value;
				out_wrote_q <= nxt_wrote;
				out_scr_q   <= nxt_scr;
			end else begin
				out_col_q   <= col_q;
				out_row_q   <= row_q;
				out_addr_q  <= res_addr_q;
				out_value_q <= held_value;
				out_wrote_q <= res_wrote_q;
				out_scr_q   <= res_scr_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_col      = out_col_q;
	assign out_row      = out_row_q;
	assign out_addr     = out_addr_q;
	assign out_value    = out_value_q;
	assign out_wrote    = out_wrote_q;
	assign out_scrolled = out_scr_q;

endmodule
